// ===== hdl/bmp_pkg.sv =====
// Shared widths, codes and control/status structs for the binomial-mod-prime block.
`default_nettype none
package bmp_pkg;

    localparam int VALUE_W     = 31;
    localparam int INDEX_W     = 12;
    localparam int COUNT_W     = 12;
    localparam int BUILT_W     = 13;
    localparam int PROD_W      = 62;
    localparam int TABLE_DEPTH = 4096;
    localparam int DIV_STEPS   = 62;
    localparam int DIV_CNT_W   = 6;

    localparam logic [VALUE_W-1:0] MOD_RESET = 31'd1000000007;
    localparam logic [VALUE_W-1:0] MOD_MIN   = 31'd2;

    localparam logic CMD_BUILD = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [2:0] {
        MUL_F_I       = 3'd0,
        MUL_A_B       = 3'd1,
        MUL_ACC_BASE  = 3'd2,
        MUL_BASE_BASE = 3'd3,
        MUL_C_ACC     = 3'd4
    } mul_sel_t;

    typedef enum logic [2:0] {
        WB_F    = 3'd0,
        WB_DEN  = 3'd1,
        WB_ACC  = 3'd2,
        WB_BASE = 3'd3,
        WB_VAL  = 3'd4
    } wb_sel_t;

    typedef enum logic [1:0] {
        RD_BOTTOM = 2'd0,
        RD_REST   = 2'd1,
        RD_TOP    = 2'd2
    } rd_sel_t;

    typedef enum logic [1:0] {
        CAP_A = 2'd0,
        CAP_B = 2'd1,
        CAP_C = 2'd2
    } cap_sel_t;

    typedef struct packed {
        logic     load;
        logic     binit;
        logic     store;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     div_start;
        logic     wb_en;
        wb_sel_t  wb_sel;
        logic     strip;
        logic     set_built;
        logic     rd_en;
        rd_sel_t  rd_sel;
        logic     cap_en;
        cap_sel_t cap_sel;
        logic     res_err;
        logic     res_zero;
        logic     out_load;
    } bmp_cmd_t;

    typedef struct packed {
        logic is_query;
        logic top_over;
        logic bot_over;
        logic cnt_mismatch;
        logic i_small;
        logic i_over;
        logic exp_zero;
        logic exp_bit0;
        logic div_done;
        logic strip_again;
        logic out_free;
    } bmp_sts_t;

endpackage
`default_nettype wire

// ===== hdl/bmp_div.sv =====
// Restoring divider, one quotient bit per cycle: quotient and remainder of a product.
`default_nettype none
module bmp_div (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [bmp_pkg::PROD_W-1:0]   dividend,
    input  wire logic [bmp_pkg::VALUE_W-1:0]  divisor,
    output logic                              busy,
    output logic                              done,
    output logic [bmp_pkg::PROD_W-1:0]        quot,
    output logic [bmp_pkg::VALUE_W-1:0]       rem
);

    logic                           busy_reg;
    logic                           done_reg;
    logic [bmp_pkg::DIV_CNT_W-1:0]  cnt_reg;
    logic [bmp_pkg::PROD_W-1:0]     dvd_reg;
    logic [bmp_pkg::VALUE_W-1:0]    rem_reg;
    logic [bmp_pkg::VALUE_W-1:0]    d_reg;

    logic [bmp_pkg::VALUE_W:0]      trial;
    logic [bmp_pkg::VALUE_W:0]      diff;
    logic                           ge;

    assign trial = {rem_reg, dvd_reg[bmp_pkg::PROD_W-1]};
    assign ge    = trial >= {1'b0, d_reg};
    assign diff  = trial - {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == bmp_pkg::DIV_CNT_W'(bmp_pkg::DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
            d_reg   <= divisor;
        end
        else if (busy_reg)
        begin
            // quotient bits shift in as dividend bits shift out
            dvd_reg <= {dvd_reg[bmp_pkg::PROD_W-2:0], ge};
            rem_reg <= ge ? diff[bmp_pkg::VALUE_W-1:0] : trial[bmp_pkg::VALUE_W-1:0];
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = dvd_reg;
    assign rem  = rem_reg;

endmodule
`default_nettype wire

// ===== hdl/bmp_dp.sv =====
// Datapath: tables, operand registers, multiplier, divider and result registers.
`default_nettype none
module bmp_dp (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [bmp_pkg::VALUE_W-1:0]   cfg_wdata,
    input  wire logic                          in_command,
    input  wire logic [bmp_pkg::INDEX_W-1:0]   in_top,
    input  wire logic [bmp_pkg::INDEX_W-1:0]   in_bottom,
    input  wire bmp_pkg::bmp_cmd_t             cmd,
    output bmp_pkg::bmp_sts_t                  sts,
    output logic [bmp_pkg::VALUE_W-1:0]        out_value,
    output logic                               out_status,
    output logic                               out_valid,
    input  wire logic                          out_ready
);

    logic [bmp_pkg::VALUE_W-1:0]  modulus_reg;
    logic [bmp_pkg::BUILT_W-1:0]  built_reg;
    logic                         out_valid_reg;

    logic                         command_reg;
    logic [bmp_pkg::INDEX_W-1:0]  top_reg;
    logic [bmp_pkg::INDEX_W-1:0]  bottom_reg;
    logic [bmp_pkg::INDEX_W-1:0]  rest_reg;
    logic [bmp_pkg::VALUE_W-1:0]  f_reg;
    logic [bmp_pkg::COUNT_W-1:0]  cnt_reg;
    logic [bmp_pkg::BUILT_W-1:0]  i_reg;
    logic [bmp_pkg::PROD_W-1:0]   x_reg;
    logic [bmp_pkg::VALUE_W-1:0]  acc_reg;
    logic [bmp_pkg::VALUE_W-1:0]  base_reg;
    logic [bmp_pkg::VALUE_W-1:0]  exp_reg;
    logic [bmp_pkg::VALUE_W-1:0]  fac_a_reg;
    logic [bmp_pkg::VALUE_W-1:0]  fac_b_reg;
    logic [bmp_pkg::VALUE_W-1:0]  fac_c_reg;
    logic [bmp_pkg::COUNT_W-1:0]  cnt_a_reg;
    logic [bmp_pkg::COUNT_W-1:0]  cnt_b_reg;
    logic [bmp_pkg::COUNT_W-1:0]  cnt_c_reg;
    logic [bmp_pkg::VALUE_W-1:0]  res_value_reg;
    logic                         res_status_reg;
    logic [bmp_pkg::VALUE_W-1:0]  out_value_reg;
    logic                         out_status_reg;
    logic [bmp_pkg::VALUE_W-1:0]  fact_rd_reg;
    logic [bmp_pkg::COUNT_W-1:0]  cnt_rd_reg;

    logic [bmp_pkg::VALUE_W-1:0]  fact_mem [bmp_pkg::TABLE_DEPTH];
    logic [bmp_pkg::COUNT_W-1:0]  cnt_mem  [bmp_pkg::TABLE_DEPTH];

    logic [bmp_pkg::VALUE_W-1:0]  m_act;
    logic [bmp_pkg::INDEX_W-1:0]  rd_addr;
    logic [bmp_pkg::VALUE_W-1:0]  mul_a;
    logic [bmp_pkg::VALUE_W-1:0]  mul_b;
    logic [bmp_pkg::PROD_W-1:0]   prod;
    logic [bmp_pkg::BUILT_W-1:0]  cnt_sum;
    logic                         div_busy;
    logic                         div_done;
    logic [bmp_pkg::PROD_W-1:0]   div_quot;
    logic [bmp_pkg::VALUE_W-1:0]  div_rem;

    // a modulus below two behaves as two
    assign m_act = (modulus_reg < bmp_pkg::MOD_MIN) ? bmp_pkg::MOD_MIN : modulus_reg;

    always_comb
    begin
        unique case (cmd.rd_sel)
            bmp_pkg::RD_BOTTOM: rd_addr = bottom_reg;
            bmp_pkg::RD_REST:   rd_addr = rest_reg;
            bmp_pkg::RD_TOP:    rd_addr = top_reg;
            default:            rd_addr = top_reg;
        endcase
    end

    always_comb
    begin
        unique case (cmd.mul_sel)
            bmp_pkg::MUL_F_I:
            begin
                mul_a = f_reg;
                mul_b = {{(bmp_pkg::VALUE_W-bmp_pkg::INDEX_W){1'b0}},
                         i_reg[bmp_pkg::INDEX_W-1:0]};
            end
            bmp_pkg::MUL_A_B:
            begin
                mul_a = fac_a_reg;
                mul_b = fac_b_reg;
            end
            bmp_pkg::MUL_ACC_BASE:
            begin
                mul_a = acc_reg;
                mul_b = base_reg;
            end
            bmp_pkg::MUL_BASE_BASE:
            begin
                mul_a = base_reg;
                mul_b = base_reg;
            end
            bmp_pkg::MUL_C_ACC:
            begin
                mul_a = fac_c_reg;
                mul_b = acc_reg;
            end
            default:
            begin
                mul_a = f_reg;
                mul_b = f_reg;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    bmp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (x_reg),
        .divisor  (m_act),
        .busy     (div_busy),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg   <= bmp_pkg::MOD_RESET;
            built_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                modulus_reg <= cfg_wdata;
                built_reg   <= '0;
            end
            else if (cmd.set_built)
            begin
                built_reg <= {1'b0, top_reg} + 1'b1;
            end
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            command_reg <= in_command;
            top_reg     <= in_top;
            bottom_reg  <= in_bottom;
            rest_reg    <= in_top - in_bottom;
        end
        if (cmd.binit)
        begin
            f_reg   <= 31'd1;
            cnt_reg <= '0;
            i_reg   <= '0;
        end
        if (cmd.store)
            i_reg <= i_reg + 1'b1;
        if (cmd.mul_en)
            x_reg <= prod;
        if (cmd.strip)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            x_reg   <= div_quot;
        end
        if (cmd.wb_en)
        begin
            unique case (cmd.wb_sel)
                bmp_pkg::WB_F:    f_reg <= div_rem;
                bmp_pkg::WB_DEN:
                begin
                    base_reg <= div_rem;
                    acc_reg  <= 31'd1;
                    exp_reg  <= m_act - bmp_pkg::MOD_MIN;
                end
                bmp_pkg::WB_ACC:  acc_reg <= div_rem;
                bmp_pkg::WB_BASE:
                begin
                    base_reg <= div_rem;
                    exp_reg  <= exp_reg >> 1;
                end
                bmp_pkg::WB_VAL:
                begin
                    res_value_reg  <= div_rem;
                    res_status_reg <= 1'b0;
                end
                default:          f_reg <= div_rem;
            endcase
        end
        if (cmd.cap_en)
        begin
            unique case (cmd.cap_sel)
                bmp_pkg::CAP_A:
                begin
                    fac_a_reg <= fact_rd_reg;
                    cnt_a_reg <= cnt_rd_reg;
                end
                bmp_pkg::CAP_B:
                begin
                    fac_b_reg <= fact_rd_reg;
                    cnt_b_reg <= cnt_rd_reg;
                end
                bmp_pkg::CAP_C:
                begin
                    fac_c_reg <= fact_rd_reg;
                    cnt_c_reg <= cnt_rd_reg;
                end
                default:
                begin
                    fac_c_reg <= fact_rd_reg;
                    cnt_c_reg <= cnt_rd_reg;
                end
            endcase
        end
        if (cmd.res_err)
        begin
            res_value_reg  <= '0;
            res_status_reg <= 1'b1;
        end
        if (cmd.res_zero)
        begin
            res_value_reg  <= '0;
            res_status_reg <= 1'b0;
        end
        if (cmd.out_load)
        begin
            out_value_reg  <= res_value_reg;
            out_status_reg <= res_status_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            fact_mem[i_reg[bmp_pkg::INDEX_W-1:0]] <= f_reg;
            cnt_mem[i_reg[bmp_pkg::INDEX_W-1:0]]  <= cnt_reg;
        end
        if (cmd.rd_en)
        begin
            fact_rd_reg <= fact_mem[rd_addr];
            cnt_rd_reg  <= cnt_mem[rd_addr];
        end
    end

    // counts add without wrap before the divisibility check
    assign cnt_sum = {1'b0, cnt_a_reg} + {1'b0, cnt_b_reg};

    assign sts.is_query     = command_reg == bmp_pkg::CMD_QUERY;
    assign sts.top_over     = {1'b0, top_reg} >= built_reg;
    assign sts.bot_over     = bottom_reg > top_reg;
    assign sts.cnt_mismatch = {1'b0, cnt_c_reg} != cnt_sum;
    assign sts.i_small      = i_reg < 13'd2;
    assign sts.i_over       = i_reg > {1'b0, top_reg};
    assign sts.exp_zero     = exp_reg == '0;
    assign sts.exp_bit0     = exp_reg[0];
    assign sts.div_done     = div_done;
    assign sts.strip_again  = (x_reg != '0) && (div_rem == '0);
    assign sts.out_free     = !out_valid_reg || out_ready;

    assign out_value  = out_value_reg;
    assign out_status = out_status_reg;
    assign out_valid  = out_valid_reg;

`ifndef ASSERT_OFF
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !div_busy)
        else $error("divider restarted while busy");
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("result overwrote an untaken result");
    a_store_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store |-> !i_reg[bmp_pkg::BUILT_W-1])
        else $error("table write beyond depth");
    a_built_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.set_built |=> (built_reg != '0))
        else $error("build left table empty");
`endif

endmodule
`default_nettype wire

// ===== hdl/bmp_ctrl.sv =====
// Controller state machine sequencing builds, table reads and the Fermat power.
`default_nettype none
module bmp_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire bmp_pkg::bmp_sts_t   sts,
    output bmp_pkg::bmp_cmd_t        cmd
);

    typedef enum logic [14:0] {
        S_IDLE     = 15'b000000000000001,
        S_DISPATCH = 15'b000000000000010,
        S_B_STORE  = 15'b000000000000100,
        S_B_CHK    = 15'b000000000001000,
        S_Q_RD0    = 15'b000000000010000,
        S_Q_RD1    = 15'b000000000100000,
        S_Q_RD2    = 15'b000000001000000,
        S_Q_RD3    = 15'b000000010000000,
        S_Q_CHK    = 15'b000000100000000,
        S_P_CHK    = 15'b000001000000000,
        S_DIV      = 15'b000010000000000,
        S_WAIT     = 15'b000100000000000,
        S_WB       = 15'b001000000000000,
        S_DONE     = 15'b010000000000000,
        S_SPARE    = 15'b100000000000000
    } state_t;

    typedef enum logic [2:0] {
        J_STRIP = 3'd0,
        J_DEN   = 3'd1,
        J_ACC   = 3'd2,
        J_BASE  = 3'd3,
        J_VAL   = 3'd4
    } job_t;

    state_t state_reg;
    state_t state_next;
    job_t   job_reg;
    job_t   job_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            job_reg   <= J_STRIP;
        end
        else
        begin
            state_reg <= state_next;
            job_reg   <= job_next;
        end
    end

    assign in_ready = state_reg == S_IDLE;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        job_next   = job_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                priority if (!sts.is_query)
                begin
                    cmd.binit  = 1'b1;
                    state_next = S_B_STORE;
                end
                else if (sts.top_over)
                begin
                    cmd.res_err = 1'b1;
                    state_next  = S_DONE;
                end
                else if (sts.bot_over)
                begin
                    cmd.res_zero = 1'b1;
                    state_next   = S_DONE;
                end
                else
                begin
                    state_next = S_Q_RD0;
                end
            end
            S_B_STORE:
            begin
                cmd.store  = 1'b1;
                state_next = S_B_CHK;
            end
            S_B_CHK:
            begin
                // entries 0 and 1 are always written
                priority if (sts.i_small)
                begin
                    state_next = S_B_STORE;
                end
                else if (sts.i_over)
                begin
                    cmd.set_built = 1'b1;
                    cmd.res_zero  = 1'b1;
                    state_next    = S_DONE;
                end
                else
                begin
                    cmd.mul_en  = 1'b1;
                    cmd.mul_sel = bmp_pkg::MUL_F_I;
                    job_next    = J_STRIP;
                    state_next  = S_DIV;
                end
            end
            S_Q_RD0:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = bmp_pkg::RD_BOTTOM;
                state_next = S_Q_RD1;
            end
            S_Q_RD1:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_sel  = bmp_pkg::RD_REST;
                cmd.cap_en  = 1'b1;
                cmd.cap_sel = bmp_pkg::CAP_A;
                state_next  = S_Q_RD2;
            end
            S_Q_RD2:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_sel  = bmp_pkg::RD_TOP;
                cmd.cap_en  = 1'b1;
                cmd.cap_sel = bmp_pkg::CAP_B;
                state_next  = S_Q_RD3;
            end
            S_Q_RD3:
            begin
                cmd.cap_en  = 1'b1;
                cmd.cap_sel = bmp_pkg::CAP_C;
                state_next  = S_Q_CHK;
            end
            S_Q_CHK:
            begin
                if (sts.cnt_mismatch)
                begin
                    cmd.res_zero = 1'b1;
                    state_next   = S_DONE;
                end
                else
                begin
                    cmd.mul_en  = 1'b1;
                    cmd.mul_sel = bmp_pkg::MUL_A_B;
                    job_next    = J_DEN;
                    state_next  = S_DIV;
                end
            end
            S_P_CHK:
            begin
                cmd.mul_en = 1'b1;
                state_next = S_DIV;
                priority if (sts.exp_zero)
                begin
                    cmd.mul_sel = bmp_pkg::MUL_C_ACC;
                    job_next    = J_VAL;
                end
                else if (sts.exp_bit0)
                begin
                    cmd.mul_sel = bmp_pkg::MUL_ACC_BASE;
                    job_next    = J_ACC;
                end
                else
                begin
                    cmd.mul_sel = bmp_pkg::MUL_BASE_BASE;
                    job_next    = J_BASE;
                end
            end
            S_DIV:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_WAIT;
            end
            S_WAIT:
            begin
                if (sts.div_done)
                    state_next = S_WB;
            end
            S_WB:
            begin
                unique case (job_reg)
                    J_STRIP:
                    begin
                        if (sts.strip_again)
                        begin
                            cmd.strip  = 1'b1;
                            state_next = S_DIV;
                        end
                        else
                        begin
                            cmd.wb_en  = 1'b1;
                            cmd.wb_sel = bmp_pkg::WB_F;
                            state_next = S_B_STORE;
                        end
                    end
                    J_DEN:
                    begin
                        cmd.wb_en  = 1'b1;
                        cmd.wb_sel = bmp_pkg::WB_DEN;
                        state_next = S_P_CHK;
                    end
                    J_ACC:
                    begin
                        // square the old base while the new accumulator lands
                        cmd.wb_en   = 1'b1;
                        cmd.wb_sel  = bmp_pkg::WB_ACC;
                        cmd.mul_en  = 1'b1;
                        cmd.mul_sel = bmp_pkg::MUL_BASE_BASE;
                        job_next    = J_BASE;
                        state_next  = S_DIV;
                    end
                    J_BASE:
                    begin
                        cmd.wb_en  = 1'b1;
                        cmd.wb_sel = bmp_pkg::WB_BASE;
                        state_next = S_P_CHK;
                    end
                    J_VAL:
                    begin
                        cmd.wb_en  = 1'b1;
                        cmd.wb_sel = bmp_pkg::WB_VAL;
                        state_next = S_DONE;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== hdl/binomial_mod_prime.sv =====
// Top level of the binomial coefficient modulo prime engine.
`default_nettype none
// Computes C(top, bottom) mod a configured prime from tables of stripped factorials
// and prime counts (4096 entries, one write and one read port each). A build request
// (tuser 0) fills entries 0..top and returns value 0. A query request (tuser 1)
// returns the coefficient, or status 1 when top lies beyond the built table. All
// modular products pass through one 31x31 multiplier and a restoring divider
// producing one quotient bit per cycle; each goes through divider start, 62 steps,
// done and writeback. A build does one modular product per entry plus one more
// division per factor of the modulus stripped out. A query does one product for the
// denominator, then for the Fermat power one per squaring and per set exponent bit,
// and a final one. One request is worked at a time; the next is taken while the
// previous result waits in the output register.
// Writing the modulus discards the built tables.
module binomial_mod_prime (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [30:0] cfg_wdata,     // modulus
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,       // [11:0] top_index, [23:12] bottom_index
    input  wire logic        s_tuser,       // command
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,       // [30:0] value, [31] zero
    output logic             m_tuser        // status
);

    bmp_pkg::bmp_cmd_t cmd;
    bmp_pkg::bmp_sts_t sts;
    logic [bmp_pkg::VALUE_W-1:0] out_value;

    bmp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bmp_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_command (s_tuser),
        .in_top     (s_tdata[11:0]),
        .in_bottom  (s_tdata[23:12]),
        .cmd        (cmd),
        .sts        (sts),
        .out_value  (out_value),
        .out_status (m_tuser),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready)
    );

    assign m_tdata = {1'b0, out_value};

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking testbench for binomial_mod_prime: directed table, then random phases.
`timescale 1ns / 1ps
module tb_top;

    typedef struct packed {
        logic [bmp_pkg::VALUE_W-1:0] value;
        logic                        status;
    } answer_t;

    typedef enum logic [1:0] {ROW_CFG, ROW_BUILD, ROW_QUERY} row_kind_t;

    typedef struct {
        row_kind_t                   kind;
        logic [30:0]                 arg;      // modulus for ROW_CFG, top index otherwise
        logic [bmp_pkg::INDEX_W-1:0] bottom;
        bit                          typed;
        answer_t                     answer;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [30:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tuser;

    // predictor state
    logic [bmp_pkg::VALUE_W-1:0] fact_tab [0:bmp_pkg::TABLE_DEPTH-1];
    logic [bmp_pkg::COUNT_W-1:0] cnt_tab  [0:bmp_pkg::TABLE_DEPTH-1];
    logic [bmp_pkg::BUILT_W-1:0] built_cnt;
    logic [bmp_pkg::VALUE_W-1:0] mod_reg;

    answer_t pending_answers[$];
    int      mismatches;
    int      answers_seen;
    int      requests_sent;
    int      cfg_writes;
    bit      hold_on;
    bit      quiet;
    event    hold_ev;

    binomial_mod_prime DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #60ms;
        $display("tb_top: timeout");
        $display("tb_top: done, errors");
        $finish;
    end

    function automatic longint unsigned eff_modulus();
        return (mod_reg < 2) ? 64'd2 : 64'(mod_reg);
    endfunction

    function automatic longint unsigned pow_mod(longint unsigned b, longint unsigned e,
                                                longint unsigned m);
        longint unsigned acc;
        acc = 1 % m;
        b = b % m;
        while (e != 0)
        begin
            if (e[0])
                acc = acc * b % m;
            b = b * b % m;
            e = e >> 1;
        end
        return acc;
    endfunction

    function automatic void fill_tables(int lim);
        longint unsigned m;
        longint unsigned prod;
        logic [bmp_pkg::COUNT_W-1:0] c;
        m = eff_modulus();
        if (lim > bmp_pkg::TABLE_DEPTH - 1)
            lim = bmp_pkg::TABLE_DEPTH - 1;
        fact_tab[0] = 1;
        fact_tab[1] = 1;
        cnt_tab[0]  = 0;
        cnt_tab[1]  = 0;
        for (int i = 2; i <= lim; i++)
        begin
            prod = 64'(fact_tab[i-1]) * i;
            c    = cnt_tab[i-1];
            while (prod != 0 && prod % m == 0)
            begin
                c++;
                prod = prod / m;
            end
            fact_tab[i] = bmp_pkg::VALUE_W'(prod % m);
            cnt_tab[i]  = c;
        end
        built_cnt = bmp_pkg::BUILT_W'(lim + 1);
    endfunction

    function automatic answer_t binomial_answer(logic cmd, int top, int bot);
        answer_t a;
        longint unsigned m;
        longint unsigned den;
        int rest;
        a = '0;
        if (cmd == bmp_pkg::CMD_BUILD)
            fill_tables(top);
        else if (top >= built_cnt)
            a.status = 1'b1;
        else if (bot <= top)
        begin
            rest = top - bot;
            // count sum compared without wrap
            if ({1'b0, cnt_tab[top]} == ({1'b0, cnt_tab[bot]} + {1'b0, cnt_tab[rest]}))
            begin
                m   = eff_modulus();
                den = 64'(fact_tab[bot]) * fact_tab[rest] % m;
                a.value = bmp_pkg::VALUE_W'(64'(fact_tab[top]) * pow_mod(den, m - 2, m) % m);
            end
        end
        return a;
    endfunction

    function automatic int gap_len();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(99);
        if (r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(3, 1);
        return $urandom_range(60, 15);
    endfunction

    // one request; tvalid is left high so back-to-back requests need no toggle
    task automatic send(logic cmd, int top, int bot, bit typed, answer_t typed_ans);
        int gap;
        answer_t a;
        gap = gap_len();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {12'(bot), 12'(top)};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        a = binomial_answer(cmd, top, bot);
        pending_answers.push_back(typed ? typed_ans : a);
        requests_sent++;
    endtask

    task automatic write_modulus(logic [30:0] v);
        s_tvalid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        mod_reg   = v;
        built_cnt = 0;
        cfg_writes++;
    endtask

    task automatic run_row(stim_row_t r);
        if (r.kind == ROW_CFG)
            write_modulus(r.arg);
        else
            send(r.kind == ROW_QUERY ? bmp_pkg::CMD_QUERY : bmp_pkg::CMD_BUILD,
                 int'(r.arg), int'(r.bottom), r.typed, r.answer);
    endtask

    // receiver: random back-pressure, result checking
    initial
    begin
        int stall;
        answer_t want;
        stall = 0;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                answers_seen++;
                if (pending_answers.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("tb_top: unexpected result value=%0d status=%0b",
                                 m_tdata[30:0], m_tuser);
                end
                else
                begin
                    want = pending_answers.pop_front();
                    if (m_tdata[30:0] !== want.value || m_tuser !== want.status)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"tb_top: mismatch value exp %0d got %0d, ",
                                      "status exp %0b got %0b"},
                                     want.value, m_tdata[30:0], want.status, m_tuser);
                    end
                end
            end
            if (hold_on)
                m_tready <= 1'b0;
            else if (stall > 0)
            begin
                stall--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                stall = gap_len();
            end
        end
    end

    // long receiver hold-off so the block backs up onto its input
    initial
    begin
        hold_on = 1'b0;
        forever
        begin
            @(hold_ev);
            hold_on = 1'b1;
            repeat (3000) @(posedge clk);
            hold_on = 1'b0;
        end
    end

    stim_row_t directed[$];

    function automatic stim_row_t mk(row_kind_t k, int a, int b, bit t, int v, bit s);
        stim_row_t r;
        r.kind         = k;
        r.arg          = 31'(a);
        r.bottom       = 12'(b);
        r.typed        = t;
        r.answer.value = 31'(v);
        r.answer.status = s;
        return r;
    endfunction

    initial
    begin
        int moduli[$];
        int nq;
        int top;
        int bot;
        int lim;
        int r;
        answer_t none;
        none = '0;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= bmp_pkg::CMD_BUILD;
        mod_reg   = bmp_pkg::MOD_RESET;
        built_cnt = 0;
        mismatches = 0;
        answers_seen = 0;
        requests_sent = 0;
        cfg_writes = 0;
        quiet = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // nothing built after reset
        directed.push_back(mk(ROW_QUERY, 0, 0, 1, 0, 1));
        directed.push_back(mk(ROW_BUILD, 0, 0, 1, 0, 0));
        directed.push_back(mk(ROW_QUERY, 0, 0, 1, 1, 0));
        // limit zero: only entry 0 is built
        directed.push_back(mk(ROW_QUERY, 1, 0, 1, 0, 1));
        directed.push_back(mk(ROW_BUILD, 4095, 4095, 1, 0, 0));
        directed.push_back(mk(ROW_QUERY, 4095, 0, 1, 1, 0));
        directed.push_back(mk(ROW_QUERY, 4095, 4095, 1, 1, 0));
        directed.push_back(mk(ROW_QUERY, 10, 3, 1, 120, 0));
        directed.push_back(mk(ROW_QUERY, 5, 6, 1, 0, 0));
        directed.push_back(mk(ROW_QUERY, 0, 4095, 1, 0, 0));
        directed.push_back(mk(ROW_QUERY, 4095, 2730, 0, 0, 0));
        // modulus write discards the tables
        directed.push_back(mk(ROW_CFG, 7, 0, 0, 0, 0));
        directed.push_back(mk(ROW_QUERY, 3, 1, 1, 0, 1));
        directed.push_back(mk(ROW_BUILD, 20, 0, 1, 0, 0));
        directed.push_back(mk(ROW_QUERY, 6, 3, 1, 6, 0));
        directed.push_back(mk(ROW_QUERY, 14, 7, 0, 0, 0));
        directed.push_back(mk(ROW_QUERY, 21, 2, 1, 0, 1));
        // small modulus treated as two, then a composite one
        directed.push_back(mk(ROW_CFG, 0, 0, 0, 0, 0));
        directed.push_back(mk(ROW_BUILD, 12, 0, 1, 0, 0));
        directed.push_back(mk(ROW_QUERY, 12, 5, 0, 0, 0));
        directed.push_back(mk(ROW_CFG, 12, 0, 0, 0, 0));
        directed.push_back(mk(ROW_BUILD, 15, 0, 1, 0, 0));
        directed.push_back(mk(ROW_QUERY, 15, 4, 0, 0, 0));
        directed.push_back(mk(ROW_CFG, 2147483647, 0, 0, 0, 0));
        directed.push_back(mk(ROW_BUILD, 30, 0, 1, 0, 0));
        directed.push_back(mk(ROW_QUERY, 30, 13, 0, 0, 0));
        foreach (directed[i])
            run_row(directed[i]);

        moduli = '{2, 3, 5, 7, 13, 31, 97, 251, 1, 0, 12, 65521, 2147483647, 1000000007};
        foreach (moduli[p])
        begin
            write_modulus(31'(moduli[p]));
            quiet = (p % 4 == 1);
            nq = (moduli[p] > 65535) ? 8 : (moduli[p] > 255) ? 25 : 70;
            lim = $urandom_range(40);
            send(bmp_pkg::CMD_BUILD, lim, $urandom_range(4095), 0, none);
            if (p == 3)
                -> hold_ev;
            for (int k = 0; k < nq; k++)
            begin
                r = $urandom_range(99);
                if (r < 70)
                begin
                    top = $urandom_range(lim);
                    bot = $urandom_range(top);
                end
                else if (r < 80)
                begin
                    top = $urandom_range(lim);
                    bot = $urandom_range(4095);
                end
                else if (r < 90)
                begin
                    top = $urandom_range(4095);
                    bot = $urandom_range(4095);
                end
                else
                begin
                    lim = $urandom_range(40);
                    send(bmp_pkg::CMD_BUILD, lim, $urandom_range(4095), 0, none);
                    continue;
                end
                send(bmp_pkg::CMD_QUERY, top, bot, 0, none);
            end
        end

        s_tvalid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        $display("tb_top: %0d requests, %0d results, %0d modulus writes",
                 requests_sent, answers_seen, cfg_writes);
        $display("tb_top: builds to full depth, prime, composite and degenerate moduli");
        if (mismatches == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
